### src/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants of the LRU page replacement core
// Holds the beat payload structs, the controller command group, the state
// machine encoding and the fixed field widths.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int LPR_FRAMES  = 16;
    localparam int LPR_PAGE_W  = 16;
    localparam int LPR_SLOT_W  = 4;
    localparam int LPR_COUNT_W = 16;
    localparam int LPR_CFG_W   = 5;

    localparam logic [LPR_CFG_W-1:0]   LPR_CFG_RESET = 5'd4;
    localparam logic [LPR_COUNT_W-1:0] LPR_COUNT_MAX = {LPR_COUNT_W{1'b1}};

    typedef struct packed {
        logic [LPR_PAGE_W-1:0] page_number;
        logic                  last_request;
    } t_lpr_req;

    typedef struct packed {
        logic                   hit;
        logic [LPR_SLOT_W-1:0]  slot;
        logic                   evicted_valid;
        logic [LPR_PAGE_W-1:0]  evicted_page;
        logic [LPR_COUNT_W-1:0] fault_count;
    } t_lpr_rsp;

    typedef struct packed {
        logic accept;  // capture the request beat
        logic lookup;  // search the frames, start the evicted page read
        logic commit;  // update frames and load the result register
        logic cfg_wr;  // write frames_in_use and start a new sequence
    } t_lpr_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_UPDATE
    } t_lpr_state;

endpackage

### src/lpr_ram.sv
// ----------------------------------------------------------------------------
// lpr_ram: generic single write port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/lpr_ctrl.sv
// ----------------------------------------------------------------------------
// lpr_ctrl: sequencing controller of the LRU page replacement core
// Steps each request through capture, lookup and update, and owns the
// handshakes of the request, result and configuration channels.
// ----------------------------------------------------------------------------
module lpr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    output lpr_pkg::t_lpr_cmd o_cmd
);
    import lpr_pkg::*;

    t_lpr_state r_state;
    t_lpr_state n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;
    logic       in_accept;

    // The result register can take a new beat when empty or being drained.
    assign out_free  = !r_out_valid || !i_out_stall;
    // A pending configuration write takes precedence over a new request.
    assign in_accept = (r_state == S_IDLE) && i_in_valid && !i_cfg_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall   = (r_state != S_IDLE) || i_cfg_valid;
        o_cfg_ready  = (r_state == S_IDLE);
        o_cmd.accept = in_accept;
        o_cmd.lookup = (r_state == S_LOOKUP);
        o_cmd.commit = (r_state == S_UPDATE) && out_free;
        o_cmd.cfg_wr = i_cfg_valid && (r_state == S_IDLE);
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### src/lpr_dp.sv
// ----------------------------------------------------------------------------
// lpr_dp: datapath of the LRU page replacement core
// Frame tags with parallel compare, recency ranks, fault counter, the
// frames_in_use register and the result register.
// ----------------------------------------------------------------------------
module lpr_dp #(
    parameter int FRAMES = lpr_pkg::LPR_FRAMES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lpr_pkg::t_lpr_cmd             i_cmd,
    input  lpr_pkg::t_lpr_req             i_in_data,
    input  logic [lpr_pkg::LPR_CFG_W-1:0] i_cfg_data,
    output lpr_pkg::t_lpr_rsp             o_out_data
);
    import lpr_pkg::*;

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RW = IW;
    localparam int CW = $clog2(FRAMES + 1);

    // Clamp the programmed frame count into 1..FRAMES.
    function automatic logic [CW-1:0] clamp_frames(input logic [LPR_CFG_W-1:0] v);
        int n;
        n = int'(v);
        if (n == 0) begin
            n = 1;
        end else if (n > FRAMES) begin
            n = FRAMES;
        end
        return CW'(n);
    endfunction

    t_lpr_req              r_req;
    logic [CW-1:0]         r_active;
    logic [FRAMES-1:0]     r_valid;
    logic [LPR_PAGE_W-1:0] r_page [FRAMES];
    logic [RW-1:0]         r_rank [FRAMES];
    logic [LPR_COUNT_W-1:0] r_faults;

    logic                  r_hit;
    logic                  r_fill;
    logic                  r_evict;
    logic [FRAMES-1:0]     r_slot_oh;
    logic [IW-1:0]         r_slot_idx;
    logic [RW-1:0]         r_slot_rank;
    t_lpr_rsp              r_out;

    logic [FRAMES-1:0]     hit_vec;
    logic [FRAMES-1:0]     empty_vec;
    logic [FRAMES-1:0]     empty_first;
    logic [FRAMES-1:0]     victim_vec;
    logic [FRAMES-1:0]     sel_oh;
    logic [IW-1:0]         sel_idx;
    logic [RW-1:0]         sel_rank;
    logic                  any_hit;
    logic                  any_empty;
    logic [RW-1:0]         last_rank;

    logic [LPR_PAGE_W-1:0]  ram_rdata;
    logic [LPR_COUNT_W-1:0] faults_next;
    logic [IW+LPR_SLOT_W-1:0] slot_wide;

    assign last_rank = RW'(r_active - 1'b1);

    // Lookup: each lane compares its tag, and the full set has exactly one
    // frame ranked oldest.
    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            logic act;
            act           = (CW'(i) < r_active);
            hit_vec[i]    = act && r_valid[i] && (r_page[i] == r_req.page_number);
            empty_vec[i]  = act && !r_valid[i];
            victim_vec[i] = act && r_valid[i] && (r_rank[i] == last_rank);
        end
    end

    assign any_hit     = |hit_vec;
    assign any_empty   = |empty_vec;
    assign empty_first = empty_vec & (~empty_vec + FRAMES'(1));

    always_comb begin
        priority if (any_hit) begin
            sel_oh = hit_vec;
        end else if (any_empty) begin
            sel_oh = empty_first;
        end else begin
            sel_oh = victim_vec;
        end
    end

    always_comb begin
        sel_idx  = '0;
        sel_rank = '0;
        for (int i = 0; i < FRAMES; i++) begin
            if (sel_oh[i]) begin
                sel_idx  = sel_idx | IW'(i);
                sel_rank = sel_rank | r_rank[i];
            end
        end
    end

    // A RAM copy of the tags supplies the page of the evicted frame.
    lpr_ram #(
        .WIDTH (LPR_PAGE_W),
        .DEPTH (FRAMES),
        .AW    (IW)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && !r_hit),
        .i_waddr (r_slot_idx),
        .i_wdata (r_req.page_number),
        .i_re    (i_cmd.lookup),
        .i_raddr (sel_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_hit || (r_faults == LPR_COUNT_MAX)) begin
            faults_next = r_faults;
        end else begin
            faults_next = r_faults + 1'b1;
        end
    end

    assign slot_wide = {{LPR_SLOT_W{1'b0}}, r_slot_idx};

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_in_data;
        end
        if (i_cmd.lookup) begin
            r_hit       <= any_hit;
            r_fill      <= !any_hit && any_empty;
            r_evict     <= !any_hit && !any_empty;
            r_slot_oh   <= sel_oh;
            r_slot_idx  <= sel_idx;
            r_slot_rank <= sel_rank;
        end
        if (i_cmd.commit) begin
            r_out.hit           <= r_hit;
            r_out.slot          <= slot_wide[LPR_SLOT_W-1:0];
            r_out.evicted_valid <= r_evict;
            r_out.evicted_page  <= r_evict ? ram_rdata : '0;
            r_out.fault_count   <= faults_next;
            for (int i = 0; i < FRAMES; i++) begin
                if (r_slot_oh[i]) begin
                    r_page[i] <= r_req.page_number;
                end
            end
        end
    end

    // Frame state: a hit or an eviction ages the frames younger than the
    // chosen one, a fill ages every resident frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= clamp_frames(LPR_CFG_RESET);
            r_valid  <= '0;
            r_faults <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.cfg_wr) begin
            r_active <= clamp_frames(i_cfg_data);
            r_valid  <= '0;
            r_faults <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            if (r_req.last_request) begin
                r_valid  <= '0;
                r_faults <= '0;
                for (int i = 0; i < FRAMES; i++) begin
                    r_rank[i] <= '0;
                end
            end else begin
                r_faults <= faults_next;
                for (int i = 0; i < FRAMES; i++) begin
                    if (r_slot_oh[i]) begin
                        r_valid[i] <= 1'b1;
                        r_rank[i]  <= '0;
                    end else if (r_valid[i] && (r_fill || (r_rank[i] < r_slot_rank))) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
            end
        end
    end

    assign o_out_data = r_out;

`ifndef SYNTHESIS
    a_hit_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lookup |-> $onehot0(hit_vec))
        else $error("page resident in more than one frame");

    a_victim_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.lookup && !any_hit && !any_empty) |-> $onehot(victim_vec))
        else $error("full frame set without a single oldest frame");

    a_slot_chosen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lookup |=> $onehot(r_slot_oh))
        else $error("lookup did not select exactly one frame");

    a_fill_lowest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.lookup && !any_hit && any_empty) |-> $onehot(empty_first))
        else $error("empty frame not selected");
`endif

endmodule

### src/lru_page_replacement_core.sv
// ----------------------------------------------------------------------------
// lru_page_replacement_core: fully associative LRU page replacement
// Each request beat is captured, then looked up in S_LOOKUP, then committed to the
// result register in S_UPDATE; a new request is taken only once the update is done,
// as set by the controller sequence and the registered read of the tag RAM.
// A stalled result holds the block in its update step; no new request is taken.
// Reset (synchronous, active low) empties all frames, clears the fault count and
// sets frames_in_use to 4; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module lru_page_replacement_core #(
    parameter int FRAMES = lpr_pkg::LPR_FRAMES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lpr_pkg::t_lpr_req             i_in_data,
    // Result channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lpr_pkg::t_lpr_rsp             o_out_data,
    // Configuration channel: frames_in_use.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lpr_pkg::LPR_CFG_W-1:0] i_cfg_data
);
    import lpr_pkg::*;

    // The controller issues one command per step; the datapath holds all
    // frame state. A frames_in_use write is taken only between requests and
    // starts a new sequence, as does a request beat marked last_request once
    // its result is formed. A frame count of zero acts as one, and counts
    // above FRAMES act as FRAMES.
    t_lpr_cmd cmd;

    lpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    // Empty frames fill from the lowest index upward; once all active frames
    // are resident, a miss replaces the frame with the oldest recency rank.
    lpr_dp #(
        .FRAMES (FRAMES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .i_cfg_data (i_cfg_data),
        .o_out_data (o_out_data)
    );

endmodule

### tb/sv/page_frame_sb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_frame_sb_pkg: result checker for the LRU page replacement core
// Keeps a private copy of the frame table, the age ranks and the fault count.
// From each accepted request it works out the result that the core must
// return, and it compares returned results against them in order.
// ----------------------------------------------------------------------------
package page_frame_sb_pkg;

    import lpr_pkg::*;

    class page_frame_scoreboard;

        logic [LPR_CFG_W-1:0]   frames_setting;
        bit                     resident [LPR_FRAMES];
        logic [LPR_PAGE_W-1:0]  held_page [LPR_FRAMES];
        int unsigned            age [LPR_FRAMES];
        logic [LPR_COUNT_W-1:0] fault_total;
        t_lpr_rsp               pending_lookups [$];
        int unsigned            failures;

        function new();
            failures = 0;
            set_frames(LPR_CFG_RESET);
        endfunction

        function void clear_frames();
            foreach (resident[i]) begin
                resident[i]  = 1'b0;
                held_page[i] = '0;
                age[i]       = 0;
            end
            fault_total = '0;
        endfunction

        // A register write also starts a new sequence.
        function void set_frames(logic [LPR_CFG_W-1:0] value);
            frames_setting = value;
            clear_frames();
        endfunction

        function int unsigned pending();
            return pending_lookups.size();
        endfunction

        // Works out the result of one accepted request and queues it.
        function void predict_lookup(t_lpr_req req);
            t_lpr_rsp    rsp;
            int unsigned n;
            int unsigned k;
            int unsigned limit;
            bit          found;
            n = (frames_setting == 0) ? 1 :
                (frames_setting > LPR_FRAMES) ? LPR_FRAMES : frames_setting;
            rsp   = '0;
            found = 1'b0;
            k     = 0;
            for (int i = 0; i < n; i++) begin
                if (!found && resident[i] && held_page[i] == req.page_number) begin
                    found = 1'b1;
                    k     = i;
                end
            end
            if (found) begin
                rsp.hit = 1'b1;
                limit   = age[k];
            end else begin
                for (int i = 0; i < n; i++) begin
                    if (!found && !resident[i]) begin
                        found = 1'b1;
                        k     = i;
                    end
                end
                if (found) begin
                    // A newly filled frame ages every other valid frame.
                    resident[k] = 1'b1;
                    limit       = LPR_FRAMES + 1;
                end else begin
                    k = 0;
                    for (int i = 1; i < n; i++) begin
                        if (age[i] > age[k])
                            k = i;
                    end
                    rsp.evicted_valid = 1'b1;
                    rsp.evicted_page  = held_page[k];
                    limit             = age[k];
                end
                held_page[k] = req.page_number;
                if (fault_total != LPR_COUNT_MAX)
                    fault_total++;
            end
            for (int i = 0; i < n; i++) begin
                if (i != k && resident[i] && age[i] < limit)
                    age[i]++;
            end
            age[k]          = 0;
            rsp.slot        = LPR_SLOT_W'(k);
            rsp.fault_count = fault_total;
            pending_lookups.push_back(rsp);
            if (req.last_request)
                clear_frames();
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(t_lpr_rsp got);
            t_lpr_rsp want;
            if (pending_lookups.size() == 0) begin
                $error("result beat 0x%0h arrived with no request outstanding", got);
                failures++;
                return;
            end
            want = pending_lookups.pop_front();
            compare_field("hit", want.hit, got.hit);
            compare_field("slot", want.slot, got.slot);
            compare_field("evicted_valid", want.evicted_valid, got.evicted_valid);
            compare_field("evicted_page", want.evicted_page, got.evicted_page);
            compare_field("fault_count", want.fault_count, got.fault_count);
        endfunction

    endclass

endpackage

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for lru_page_replacement_core
// Drives page requests and frames_in_use writes, throttles both channels at
// random, and checks every result beat against a predicted frame table.
// Covers fill order, hits, evictions, sequence ends, all register corners and
// a short one-frame stream that faults on every request.
// ----------------------------------------------------------------------------
module tb;

    import lpr_pkg::*;
    import page_frame_sb_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_lpr_req             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_lpr_rsp             o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [LPR_CFG_W-1:0] i_cfg_data;

    // When set, both the request side and the result side idle at random.
    bit throttle_en;

    page_frame_scoreboard sb;

    // Opening sequence with the reset value of four frames. Each entry is
    // {page_number, last_request}. It fills the frames from slot 0 upward,
    // hits, evicts the oldest page four times, ends a sequence, starts a
    // fresh one and also ends a sequence of a single request.
    localparam logic [LPR_PAGE_W:0] OPENING [14] = '{
        {16'h0000, 1'b0}, {16'hFFFF, 1'b0}, {16'h0001, 1'b0}, {16'h0000, 1'b0},
        {16'h0002, 1'b0}, {16'h0003, 1'b0}, {16'hFFFF, 1'b0}, {16'h0002, 1'b0},
        {16'h0000, 1'b0}, {16'h8000, 1'b0}, {16'h7FFF, 1'b1}, {16'h0003, 1'b0},
        {16'h0003, 1'b1}, {16'hFFFF, 1'b1}
    };

    // Register settings for the random phases: the smallest and largest legal
    // counts, zero (acts as one), the all-ones code and one just past the
    // frame count (both act as sixteen). Later phases pick their own.
    localparam logic [LPR_CFG_W-1:0] PHASE_FRAMES [5] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17};
    localparam int                   PHASES           = 8;
    localparam int                   ITEMS_PER_PHASE  = 45;
    localparam int                   ONE_FRAME_ITEMS  = 12;

    lru_page_replacement_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // A fixed limit well beyond the slowest correct run, even with both sides idling.
    initial begin
        #2ms;
        $display("** lru_page_replacement_core: FAILED **");
        $finish;
    end

    function automatic bit idle_now();
        return throttle_en && ($urandom_range(99) < 30);
    endfunction

    // The result side stalls at random; the value is set at the falling edge
    // so the rising edge always sees a settled stall.
    always @(negedge i_clk) begin
        i_out_stall <= idle_now();
    end

    // Every accepted result beat is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_data);
        end
    end

    // Offers one request beat and holds it until the core takes it. Valid is
    // left high, so back to back requests never drop it in between.
    task automatic send_request(logic [LPR_PAGE_W-1:0] page, logic last);
        t_lpr_req req;
        req.page_number = page;
        req.last_request = last;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        sb.predict_lookup(req);
    endtask

    task automatic hold_off(int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // Lets the pipeline drain: drops the request valid and waits until all
    // predicted results are back.
    task automatic wait_drained();
        hold_off(1);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_frames(logic [LPR_CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        sb.set_frames(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One request drawn mostly from a small working set, so that hits and
    // evictions both happen often; about one in ten is a fully random page.
    task automatic send_random(logic [LPR_PAGE_W-1:0] base, int unsigned spread);
        logic [LPR_PAGE_W-1:0] page;
        if ($urandom_range(9) == 0)
            page = LPR_PAGE_W'($urandom_range(16'hFFFF));
        else
            page = base + LPR_PAGE_W'($urandom_range(spread));
        if (idle_now())
            hold_off($urandom_range(1, 4));
        send_request(page, $urandom_range(99) < 3);
    endtask

    initial begin
        logic [LPR_CFG_W-1:0]  setting;
        logic [LPR_PAGE_W-1:0] base;
        int unsigned           active;

        sb          = new();
        throttle_en = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening with the reset frame count, first without and then
        // with throttling so stalls land on the same well-known sequence.
        foreach (OPENING[i]) begin
            send_request(OPENING[i][LPR_PAGE_W:1], OPENING[i][0]);
        end
        throttle_en = 1'b1;
        foreach (OPENING[i]) begin
            if (idle_now())
                hold_off($urandom_range(1, 3));
            send_request(OPENING[i][LPR_PAGE_W:1], OPENING[i][0]);
        end

        // Random phases, each under its own register setting. Apart from the first,
        // the write may land on frames that still hold pages, so it also checks that a
        // write starts a new sequence. Phase 2 runs with no idling at all.
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            setting = (p < 5) ? PHASE_FRAMES[p] : LPR_CFG_W'($urandom_range(31));
            write_frames(setting);
            active      = (setting == 0) ? 1 : (setting > LPR_FRAMES) ? LPR_FRAMES : setting;
            base        = LPR_PAGE_W'($urandom_range(16'hFFFF));
            throttle_en = (p != 2);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // Once, the sender stops until every outstanding result has
                // come back, then carries on in the same sequence.
                if (p == 3 && i == ITEMS_PER_PHASE / 2)
                    wait_drained();
                send_random(base, active + 3);
            end
        end

        // One frame: two alternating pages fault on every request, so each beat after
        // the first evicts the other page and the fault count climbs by one.
        // The last beat ends the sequence and the next one must count from one.
        wait_drained();
        throttle_en = 1'b0;
        write_frames(5'd1);
        for (int i = 0; i < ONE_FRAME_ITEMS; i++) begin
            send_request(i[0] ? 16'hA5A5 : 16'h5A5A, i == ONE_FRAME_ITEMS - 1);
        end
        send_request(16'h5A5A, 1'b0);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("** lru_page_replacement_core: PASSED **");
        end else begin
            $display("** lru_page_replacement_core: FAILED **");
        end
        $finish;
    end

endmodule

### files.f
src/lpr_pkg.sv
src/lpr_ram.sv
src/lpr_ctrl.sv
src/lpr_dp.sv
src/lru_page_replacement_core.sv
tb/sv/page_frame_sb_pkg.sv
tb/sv/tb.sv
